// File: sv/ofb_pkg.sv
package ofb_pkg;

    // Field widths
    localparam int PIX_W  = 8;
    localparam int COL_W  = 12;
    localparam int WID_W  = 13;
    localparam int THR_W  = 8;
    localparam int NCH    = 3;

    // Blend datapath widths: span fits the width field, numerator < 256 * span
    localparam int SPAN_W = WID_W;
    localparam int QUO_W  = PIX_W;
    localparam int NUM_W  = SPAN_W + PIX_W;

    // Configuration port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    localparam int MAX_WIDTH_DEF = 4096;

    localparam logic [COL_W-1:0] START_RST = COL_W'(0);
    localparam logic [WID_W-1:0] WIDTH_RST = WID_W'(640);
    localparam logic [THR_W-1:0] THR_RST   = THR_W'(50);

    // Register index, byte address 4*index
    typedef enum logic [ADDR_W-3:0] {
        REG_OVERLAP_START  = 2'd0,
        REG_IMAGE_WIDTH    = 2'd1,
        REG_DARK_THRESHOLD = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [COL_W-1:0] overlap_start;
        logic [WID_W-1:0] image_width;
        logic [THR_W-1:0] dark_threshold;
    } t_cfg;

    // Word leaving the front stage: both pixels plus the two weights and divisor
    typedef struct packed {
        logic                       valid;
        logic [NCH-1:0][PIX_W-1:0]  scene;
        logic [NCH-1:0][PIX_W-1:0]  warped;
        logic [SPAN_W-1:0]          ws;
        logic [SPAN_W-1:0]          ww;
        logic [SPAN_W-1:0]          div;
    } t_front;

    // Word moving along the divider cells
    typedef struct packed {
        logic                       valid;
        logic [NCH-1:0][NUM_W-1:0]  rem;
        logic [NCH-1:0][QUO_W-1:0]  quo;
        logic [SPAN_W-1:0]          div;
    } t_div;

endpackage

// File: sv/ofb_in_if.sv
interface ofb_in_if
    import ofb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column;
    logic [PIX_W-1:0] scene_b;
    logic [PIX_W-1:0] scene_g;
    logic [PIX_W-1:0] scene_r;
    logic [PIX_W-1:0] warped_b;
    logic [PIX_W-1:0] warped_g;
    logic [PIX_W-1:0] warped_r;

    modport source (
        output valid, column, scene_b, scene_g, scene_r, warped_b, warped_g, warped_r,
        input  ready
    );
    modport sink (
        input  valid, column, scene_b, scene_g, scene_r, warped_b, warped_g, warped_r,
        output ready
    );
endinterface

// File: sv/ofb_out_if.sv
interface ofb_out_if
    import ofb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_b;
    logic [PIX_W-1:0] out_g;
    logic [PIX_W-1:0] out_r;

    modport source (
        output valid, out_b, out_g, out_r,
        input  ready
    );
    modport sink (
        input  valid, out_b, out_g, out_r,
        output ready
    );
endinterface

// File: sv/ofb_cfg.sv
module ofb_cfg
    import ofb_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg             r_cfg;
    t_cfg             n_cfg;
    t_reg_idx         idx;
    logic [WID_W-1:0] wid_raw;

    assign idx     = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wid_raw = pwdata[WID_W-1:0];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Decode a write; saturate the width at the maximum
    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (idx)
                REG_OVERLAP_START:  n_cfg.overlap_start  = pwdata[COL_W-1:0];
                REG_IMAGE_WIDTH: begin
                    n_cfg.image_width = (32'(wid_raw) > 32'(MAX_WIDTH)) ?
                                        WID_W'(MAX_WIDTH) : wid_raw;
                end
                REG_DARK_THRESHOLD: n_cfg.dark_threshold = pwdata[THR_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.overlap_start  <= START_RST;
            r_cfg.image_width    <= WIDTH_RST;
            r_cfg.dark_threshold <= THR_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read back
    always_comb begin
        case (idx)
            REG_OVERLAP_START:  prdata = DATA_W'(r_cfg.overlap_start);
            REG_IMAGE_WIDTH:    prdata = DATA_W'(r_cfg.image_width);
            REG_DARK_THRESHOLD: prdata = DATA_W'(r_cfg.dark_threshold);
            default:            prdata = '0;
        endcase
    end

endmodule

// File: sv/ofb_front.sv
module ofb_front
    import ofb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    ofb_in_if.sink i_pix,
    input  logic   i_adv,
    output t_front o_word
);

    t_front            r_word;
    t_front            n_word;
    logic              col_lo;
    logic              col_hi;
    logic              dark;
    logic [COL_W-1:0]  col_ofs;
    logic [SPAN_W-1:0] span;
    logic              take;

    assign i_pix.ready = !r_word.valid || i_adv;
    assign take        = i_pix.valid && i_pix.ready;
    assign o_word      = r_word;

    // Classify the column and pick weights; pass-through cases divide by one
    always_comb begin
        col_lo  = i_pix.column < i_cfg.overlap_start;
        col_hi  = {1'b0, i_pix.column} >= i_cfg.image_width;
        dark    = (i_pix.warped_b < i_cfg.dark_threshold) &&
                  (i_pix.warped_g < i_cfg.dark_threshold) &&
                  (i_pix.warped_r < i_cfg.dark_threshold);
        col_ofs = i_pix.column - i_cfg.overlap_start;
        span    = i_cfg.image_width - {1'b0, i_cfg.overlap_start};

        n_word.valid  = i_pix.valid;
        n_word.scene  = {i_pix.scene_r, i_pix.scene_g, i_pix.scene_b};
        n_word.warped = {i_pix.warped_r, i_pix.warped_g, i_pix.warped_b};
        if (col_lo || (!col_hi && dark)) begin
            n_word.ws  = SPAN_W'(1);
            n_word.ww  = '0;
            n_word.div = SPAN_W'(1);
        end else if (col_hi) begin
            n_word.ws  = '0;
            n_word.ww  = SPAN_W'(1);
            n_word.div = SPAN_W'(1);
        end else begin
            n_word.ws  = span - SPAN_W'(col_ofs);
            n_word.ww  = SPAN_W'(col_ofs);
            n_word.div = span;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_word.valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word.scene  <= n_word.scene;
            r_word.warped <= n_word.warped;
            r_word.ws     <= n_word.ws;
            r_word.ww     <= n_word.ww;
            r_word.div    <= n_word.div;
        end
    end

endmodule

// File: sv/ofb_mul.sv
module ofb_mul
    import ofb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_front i_word,
    output logic   o_ready,
    input  logic   i_adv,
    output t_div   o_word
);

    t_div r_word;
    t_div n_word;
    logic take;

    assign o_ready = !r_word.valid || i_adv;
    assign take    = i_word.valid && o_ready;
    assign o_word  = r_word;

    // Weighted sum per channel: scene * ws + warped * ww
    always_comb begin
        n_word.valid = i_word.valid;
        n_word.div   = i_word.div;
        n_word.quo   = '0;
        for (int k = 0; k < NCH; k++) begin
            n_word.rem[k] = NUM_W'(i_word.scene[k])  * NUM_W'(i_word.ws) +
                            NUM_W'(i_word.warped[k]) * NUM_W'(i_word.ww);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else if (o_ready) begin
            r_word.valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word.rem <= n_word.rem;
            r_word.quo <= n_word.quo;
            r_word.div <= n_word.div;
        end
    end

endmodule

// File: sv/ofb_cell.sv
module ofb_cell
    import ofb_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_div i_word,
    output logic o_ready,
    input  logic i_adv,
    output t_div o_word
);

    t_div             r_word;
    t_div             n_word;
    logic [NUM_W-1:0] dshift;
    logic             take;

    assign o_ready = !r_word.valid || i_adv;
    assign take    = i_word.valid && o_ready;
    assign o_word  = r_word;

    // One restoring step: subtract the shifted divisor where it fits
    always_comb begin
        dshift = NUM_W'(i_word.div) << BIT;
        n_word = i_word;
        for (int k = 0; k < NCH; k++) begin
            if (i_word.rem[k] >= dshift) begin
                n_word.rem[k]      = i_word.rem[k] - dshift;
                n_word.quo[k][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else if (o_ready) begin
            r_word.valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word.rem <= n_word.rem;
            r_word.quo <= n_word.quo;
            r_word.div <= n_word.div;
        end
    end

endmodule

// File: sv/overlap_feather_blend.sv
// Overlap feather blend: stitches one BGR pixel per word.
//
// i_pix carries a column, the second camera's pixel and the matching warped
// pixel; o_pix returns the stitched pixel, one output word per input word,
// in order. Left of the overlap the scene pixel passes, past the image
// width the warped pixel passes, and inside the overlap the two are mixed
// as floor((scene*(W-d) + warped*d)/W) unless the warped pixel is dark.
// The APB port holds overlap_start (0x0), image_width (0x4) and
// dark_threshold (0x8); write it only while no word is in flight.
//
// Ten registers lie in a row: one front stage, one multiply stage and eight
// divider cells, each cell settling one quotient bit; the last cell register
// drives o_pix. Throughput is one word per cycle while the receiver keeps
// taking words. Every stage holds its word while the next one is full, so a
// stalled receiver backs up stage by stage and i_pix.ready falls only when
// all stages are full. Empty stages keep filling while a result waits. Reset
// empties the pipeline and loads the register reset values (0, 640, 50).
module overlap_feather_blend
    import ofb_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ofb_in_if.sink            i_pix,
    ofb_out_if.source         o_pix,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int NCELL = QUO_W;

    t_cfg               cfg;
    t_front             w_front;
    logic               mul_rdy;
    t_div               w_div  [NCELL+1];
    logic [NCELL:0]     cell_rdy;

    ofb_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ofb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pix   (i_pix),
        .i_adv   (mul_rdy),
        .o_word  (w_front)
    );

    ofb_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (w_front),
        .o_ready (mul_rdy),
        .i_adv   (cell_rdy[0]),
        .o_word  (w_div[0])
    );

    // Divider chain, most significant quotient bit first
    assign cell_rdy[NCELL] = o_pix.ready;

    for (genvar c = 0; c < NCELL; c++) begin : g_cell
        ofb_cell #(
            .BIT (NCELL - 1 - c)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (w_div[c]),
            .o_ready (cell_rdy[c]),
            .i_adv   (cell_rdy[c+1]),
            .o_word  (w_div[c+1])
        );
    end

    // Last cell register is the output register
    assign o_pix.valid = w_div[NCELL].valid;
    assign o_pix.out_b = w_div[NCELL].quo[0];
    assign o_pix.out_g = w_div[NCELL].quo[1];
    assign o_pix.out_r = w_div[NCELL].quo[2];

    // A ready receiver lets every stage advance
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.ready |-> i_pix.ready)
        else $error("input stalled while output ready");

    // Weights always sum to the divisor
    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_front.valid |->
            (({1'b0, w_front.ws} + {1'b0, w_front.ww}) == {1'b0, w_front.div}))
        else $error("blend weights do not sum to divisor");

    // Never divide by zero
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_front.valid |-> (w_front.div != '0))
        else $error("zero divisor entered the divider");

    // Final remainder below the divisor on every channel
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div[NCELL].valid |->
            ((w_div[NCELL].rem[0] < NUM_W'(w_div[NCELL].div)) &&
             (w_div[NCELL].rem[1] < NUM_W'(w_div[NCELL].div)) &&
             (w_div[NCELL].rem[2] < NUM_W'(w_div[NCELL].div))))
        else $error("divider remainder out of range");

endmodule

// File: dv/stitch_checker.sv
`timescale 1ns / 100ps

module stitch_checker
    import ofb_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ofb_in_if                 i_pix,
    ofb_out_if                o_pix,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                o_fail_count,
    output int                o_pending
);

    // Channel order: 0 = blue, 1 = green, 2 = red
    typedef logic [NCH-1:0][PIX_W-1:0] t_bgr;

    t_cfg blend_cfg;
    t_bgr stitched_q[$];
    int   fail_total;

    // Stitched pixel for one column under the given overlap setup
    function automatic t_bgr stitch_pixel(t_cfg c, logic [COL_W-1:0] col, t_bgr scene,
                                          t_bgr warped);
        t_bgr        res;
        int unsigned pos;
        int unsigned first;
        int unsigned last;
        int unsigned thr;
        int unsigned d;
        int unsigned span;
        logic        dark;
        int          k;
        pos   = col;
        first = c.overlap_start;
        last  = c.image_width;
        thr   = c.dark_threshold;
        if (pos < first) begin
            res = scene;
        end else if (pos >= last) begin
            res = warped;
        end else begin
            // Inside the overlap: an all-dark warped pixel counts as empty
            dark = (warped[0] < thr) && (warped[1] < thr) && (warped[2] < thr);
            d    = pos - first;
            span = last - first;
            for (k = 0; k < NCH; k++) begin
                if (dark) begin
                    res[k] = scene[k];
                end else begin
                    res[k] = PIX_W'((scene[k] * (span - d) + warped[k] * d) / span);
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_bgr        scene;
        t_bgr        warped;
        t_bgr        want;
        t_bgr        got;
        logic [WID_W-1:0] width_wr;
        if (!i_rst_n) begin
            stitched_q.delete();
            blend_cfg <= '{overlap_start: START_RST, image_width: WIDTH_RST,
                           dark_threshold: THR_RST};
            fail_total = 0;
        end else begin
            // Predict each accepted word with the setup in force at this edge
            if (i_pix.valid && i_pix.ready) begin
                scene  = {i_pix.scene_r, i_pix.scene_g, i_pix.scene_b};
                warped = {i_pix.warped_r, i_pix.warped_g, i_pix.warped_b};
                want   = stitch_pixel(blend_cfg, i_pix.column, scene, warped);
                stitched_q = {stitched_q, want};
            end

            // Compare each delivered word with the oldest prediction
            if (o_pix.valid && o_pix.ready) begin
                got = {o_pix.out_r, o_pix.out_g, o_pix.out_b};
                if (stitched_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("%0t: unexpected output word b=%0d g=%0d r=%0d",
                                 $realtime, got[0], got[1], got[2]);
                    end
                end else begin
                    want = stitched_q.pop_front();
                    if (got[0] !== want[0] || got[1] !== want[1] || got[2] !== want[2]) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("%0t: exp b=%0d g=%0d r=%0d got b=%0d g=%0d r=%0d",
                                     $realtime, want[0], want[1], want[2],
                                     got[0], got[1], got[2]);
                        end
                    end
                end
            end

            // Track register writes; out-of-range indexes are dropped
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[ADDR_W-1:2]))
                    REG_OVERLAP_START: begin
                        blend_cfg.overlap_start <= pwdata[COL_W-1:0];
                    end
                    REG_IMAGE_WIDTH: begin
                        width_wr = pwdata[WID_W-1:0];
                        if (width_wr > MAX_WIDTH) begin
                            blend_cfg.image_width <= WID_W'(MAX_WIDTH);
                        end else begin
                            blend_cfg.image_width <= width_wr;
                        end
                    end
                    REG_DARK_THRESHOLD: begin
                        blend_cfg.dark_threshold <= pwdata[THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending    <= stitched_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ofb_pkg::*;

    typedef logic [NCH-1:0][PIX_W-1:0] t_bgr;

    // Index past the last register, written once to check it is ignored
    localparam logic [ADDR_W-3:0] REG_SPARE_IDX = 2'd3;
    localparam int NUM_PHASES      = 7;
    localparam int WORDS_PER_PHASE = 200;
    localparam int DRAIN_CYCLES    = 16;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                pending;

    // Stimulus-side copy of the active setup, used only to aim columns
    int unsigned cur_start;
    int unsigned cur_width;
    int unsigned cur_thr;
    int          src_idle;
    int          snk_idle;

    ofb_in_if  pix_in();
    ofb_out_if pix_out();

    overlap_feather_blend dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    stitch_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_in),
        .o_pix        (pix_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Receiver: stall at random per the current idle rate
    always @(posedge i_clk) begin
        pix_out.ready <= ($urandom_range(99) >= snk_idle);
    end

    // Hard stop in case the pipeline hangs
    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    // Present one word, optionally after idle cycles, and hold it until accepted
    task automatic send_pixel(int unsigned col, t_bgr scene, t_bgr warped);
        while ($urandom_range(99) < src_idle) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.column   <= COL_W'(col);
        pix_in.scene_b  <= scene[0];
        pix_in.scene_g  <= scene[1];
        pix_in.scene_r  <= scene[2];
        pix_in.warped_b <= warped[0];
        pix_in.warped_g <= warped[1];
        pix_in.warped_r <= warped[2];
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
    endtask

    // Lower valid and wait until every predicted word has come back
    task automatic drain_pipe();
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup, access, then idle with psel low
    task automatic write_reg(logic [ADDR_W-3:0] idx, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load all three registers; upper data bits carry noise
    task automatic load_blend_setup(int unsigned start, int unsigned width_raw,
                                    int unsigned thr);
        logic [DATA_W-1:0] data;
        data = $urandom();
        data[COL_W-1:0] = COL_W'(start);
        write_reg(REG_OVERLAP_START, data);
        data = $urandom();
        data[WID_W-1:0] = WID_W'(width_raw);
        write_reg(REG_IMAGE_WIDTH, data);
        data = $urandom();
        data[THR_W-1:0] = THR_W'(thr);
        write_reg(REG_DARK_THRESHOLD, data);
        cur_start = start & 12'hFFF;
        cur_width = (width_raw & 13'h1FFF) > MAX_WIDTH_DEF ? MAX_WIDTH_DEF
                                                           : (width_raw & 13'h1FFF);
        cur_thr   = thr & 8'hFF;
    endtask

    // Random word aimed mostly at the overlap and its edges
    task automatic send_random_pixel();
        int unsigned col;
        int unsigned pick;
        int          k;
        t_bgr        scene;
        t_bgr        warped;
        pick = $urandom_range(99);
        if (pick < 55 && cur_width > cur_start) begin
            col = $urandom_range(cur_width - 1, cur_start);
        end else if (pick < 75) begin
            case ($urandom_range(3))
                0: col = cur_start - 1;
                1: col = cur_start;
                2: col = cur_width - 1;
                default: col = cur_width;
            endcase
        end else begin
            col = $urandom_range(4095);
        end
        col = col & 12'hFFF;

        pick = $urandom_range(99);
        for (k = 0; k < NCH; k++) begin
            scene[k] = PIX_W'($urandom_range(255));
            if (pick < 30 && cur_thr > 0) begin
                warped[k] = PIX_W'($urandom_range(cur_thr - 1, 0));
            end else if (pick < 45) begin
                // Straddle the dark threshold
                warped[k] = PIX_W'(cur_thr - $urandom_range(1));
            end else begin
                warped[k] = PIX_W'($urandom_range(255));
            end
        end
        send_pixel(col, scene, warped);
    endtask

    initial begin
        int unsigned ph_start[NUM_PHASES];
        int unsigned ph_width[NUM_PHASES];
        int unsigned ph_thr[NUM_PHASES];
        int          phase;
        int          n;

        ph_start = '{100, 0, 4095, 500, 0, 0, 2048};
        ph_width = '{300, 4096, 8191, 300, 0, 0, 2100};
        ph_thr   = '{50, 0, 255, 128, 255, 0, 200};

        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        pix_in.valid    <= 1'b0;
        pix_in.column   <= '0;
        pix_in.scene_b  <= '0;
        pix_in.scene_g  <= '0;
        pix_in.scene_r  <= '0;
        pix_in.warped_b <= '0;
        pix_in.warped_g <= '0;
        pix_in.warped_r <= '0;
        cur_start = START_RST;
        cur_width = WIDTH_RST;
        cur_thr   = THR_RST;
        src_idle  = 37;
        snk_idle  = 64;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset setup, dark pixel at the overlap start, both edges
        send_pixel(0, {8'hFF, 8'hFF, 8'hFF}, {8'h00, 8'h00, 8'h00});
        send_pixel(639, {8'h00, 8'h00, 8'h00}, {8'hFF, 8'hFF, 8'hFF});
        send_pixel(640, {8'hFF, 8'hFF, 8'hFF}, {8'h12, 8'h34, 8'h56});
        send_pixel(4095, {8'h00, 8'h00, 8'h00}, {8'hFF, 8'hFF, 8'hFF});
        send_pixel(320, {8'h80, 8'h00, 8'hFF}, {8'd49, 8'd49, 8'd49});
        send_pixel(320, {8'h80, 8'h00, 8'hFF}, {8'd50, 8'd49, 8'd49});
        drain_pipe();

        // Directed: narrow overlap, dark pixel inside and outside it
        load_blend_setup(100, 300, 50);
        send_pixel(0, {8'hFF, 8'h00, 8'hFF}, {8'hFF, 8'hFF, 8'hFF});
        send_pixel(99, {8'h01, 8'h02, 8'h03}, {8'hFF, 8'hFF, 8'hFF});
        send_pixel(100, {8'h10, 8'h20, 8'h30}, {8'hF0, 8'hE0, 8'hD0});
        send_pixel(299, {8'hFF, 8'hFF, 8'hFF}, {8'hFF, 8'hFF, 8'hFF});
        send_pixel(299, {8'h00, 8'h00, 8'h00}, {8'hFF, 8'hFF, 8'hFF});
        send_pixel(300, {8'hFF, 8'hFF, 8'hFF}, {8'h00, 8'h00, 8'h00});
        send_pixel(200, {8'hFF, 8'hFF, 8'hFF}, {8'h00, 8'h00, 8'h00});
        send_pixel(50, {8'hAA, 8'h55, 8'hAA}, {8'h00, 8'h00, 8'h00});
        send_pixel(350, {8'hAA, 8'h55, 8'hAA}, {8'h00, 8'h00, 8'h00});
        send_pixel(200, {8'h00, 8'h00, 8'hFF}, {8'h00, 8'h00, 8'hFF});
        send_pixel(4095, {8'h00, 8'h00, 8'h00}, {8'h7F, 8'h80, 8'h81});
        drain_pipe();

        // Directed: overlap of one column, saturated width, top threshold
        load_blend_setup(4095, 8191, 255);
        send_pixel(4095, {8'hAB, 8'hCD, 8'hEF}, {8'hFE, 8'hFE, 8'hFE});
        send_pixel(4095, {8'hAB, 8'hCD, 8'hEF}, {8'h00, 8'h00, 8'hFF});
        send_pixel(4094, {8'h11, 8'h22, 8'h33}, {8'hFF, 8'hFF, 8'hFF});
        drain_pipe();

        // Directed: zero width, empty overlap
        load_blend_setup(0, 0, 0);
        send_pixel(0, {8'hFF, 8'hFF, 8'hFF}, {8'h01, 8'h02, 8'h03});
        send_pixel(4095, {8'hFF, 8'hFF, 8'hFF}, {8'h04, 8'h05, 8'h06});
        drain_pipe();

        // Random phases, each under its own setup, with idle patterns set per group of phases
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase < 3) begin
                src_idle = 37;
                snk_idle = 64;
            end else if (phase < 5) begin
                src_idle = 64;
                snk_idle = 37;
            end else begin
                src_idle = 0;
                snk_idle = 0;
            end
            if (phase == 5) begin
                write_reg(REG_SPARE_IDX, $urandom());
                load_blend_setup($urandom_range(4095), $urandom_range(8191),
                                 $urandom_range(255));
            end else begin
                load_blend_setup(ph_start[phase], ph_width[phase], ph_thr[phase]);
            end
            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                send_random_pixel();
            end
            drain_pipe();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
